// ===== design/atf_pkg.sv =====
package atf_pkg;

    // Range limits for framing
    localparam logic [15:0] SPEED_MAX = 16'd9999;
    localparam logic [15:0] COUNT_MAX = 16'd999;

    // Frame layout
    localparam int          FRAME_LEN  = 11;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;
    localparam logic [7:0]  HEAD_SPEED = 8'h52;
    localparam logic [7:0]  HEAD_COUNT = 8'h41;
    localparam logic [7:0]  LINE_FEED  = 8'h0A;

    // Checksum contribution of the fixed bytes: two headers plus the seven
    // 0x30 digit offsets, taken modulo 256
    localparam logic [7:0]  CSUM_BASE =
        8'((32'(HEAD_SPEED) + 32'(HEAD_COUNT) + 7 * 32'(ASCII_ZERO)) % 256);

    // Byte positions within the frame
    typedef enum logic [3:0] {
        POS_HEAD_SPEED = 4'd0,
        POS_SPD_TH     = 4'd1,
        POS_SPD_HU     = 4'd2,
        POS_SPD_TE     = 4'd3,
        POS_SPD_ON     = 4'd4,
        POS_HEAD_COUNT = 4'd5,
        POS_CNT_HU     = 4'd6,
        POS_CNT_TE     = 4'd7,
        POS_CNT_ON     = 4'd8,
        POS_CSUM       = 4'd9,
        POS_LINE_FEED  = 4'd10
    } frame_pos_t;

    // Decimal digits and checksum of one frame
    typedef struct packed {
        logic [3:0] spd_th;
        logic [3:0] spd_hu;
        logic [3:0] spd_te;
        logic [3:0] spd_on;
        logic [3:0] cnt_hu;
        logic [3:0] cnt_te;
        logic [3:0] cnt_on;
        logic [7:0] csum;
    } frame_t;

    // Decimal digit of v at weight unit, for v below ten times unit
    function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] unit);
        logic [3:0]  d;
        logic [13:0] thr;
        d = 4'd0;
        for (int i = 1; i < 10; i++) begin
            thr = 14'(i * 32'(unit));
            if (v >= thr) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    // Remainder after removing digit d at weight unit
    function automatic logic [13:0] dec_rem(input logic [13:0] v, input logic [3:0] d,
                                            input logic [13:0] unit);
        logic [13:0] sub;
        sub = 14'(32'(d) * 32'(unit));
        return v - sub;
    endfunction

    // ASCII character of one decimal digit
    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return ASCII_ZERO | {4'h0, d};
    endfunction

endpackage

// ===== design/atf_digits.sv =====
module atf_digits
    import atf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_speed,
    input  logic [15:0] in_count,
    output logic        out_valid,
    input  logic        out_ready,
    output frame_t      out_frame
);

    // Stage 1: range check, out-of-range transactions are dropped here
    logic        v1_reg;
    logic [13:0] spd1_reg;
    logic [9:0]  cnt1_reg;
    // Stage 2: thousands digit of speed
    logic        v2_reg;
    logic [3:0]  spd_th2_reg;
    logic [9:0]  spd2_reg;
    logic [9:0]  cnt2_reg;
    // Stage 3: hundreds digits
    logic        v3_reg;
    logic [3:0]  spd_th3_reg, spd_hu3_reg, cnt_hu3_reg;
    logic [6:0]  spd3_reg, cnt3_reg;
    // Stage 4: tens and ones digits
    logic        v4_reg;
    frame_t      f4_reg;
    // Stage 5: checksum
    logic        v5_reg;
    frame_t      f5_reg;
    frame_t      f5_next;

    logic ready1, ready2, ready3, ready4, ready5;
    logic in_range;

    logic [3:0]  th_d, sh_d, ch_d, st_d, ct_d;
    logic [13:0] s_rem2, s_rem3, c_rem3;
    logic [13:0] s_rem4, c_rem4;
    logic [7:0]  dsum;

    // A stage loads when empty or when its contents move on
    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign in_range = (in_speed <= SPEED_MAX) && (in_count <= COUNT_MAX);

    // Digit arithmetic per stage
    always_comb begin
        th_d   = dec_digit(spd1_reg, 14'd1000);
        s_rem2 = dec_rem(spd1_reg, th_d, 14'd1000);
        sh_d   = dec_digit({4'd0, spd2_reg}, 14'd100);
        s_rem3 = dec_rem({4'd0, spd2_reg}, sh_d, 14'd100);
        ch_d   = dec_digit({4'd0, cnt2_reg}, 14'd100);
        c_rem3 = dec_rem({4'd0, cnt2_reg}, ch_d, 14'd100);
        st_d   = dec_digit({7'd0, spd3_reg}, 14'd10);
        s_rem4 = dec_rem({7'd0, spd3_reg}, st_d, 14'd10);
        ct_d   = dec_digit({7'd0, cnt3_reg}, 14'd10);
        c_rem4 = dec_rem({7'd0, cnt3_reg}, ct_d, 14'd10);
        dsum   = 8'(f4_reg.spd_th) + 8'(f4_reg.spd_hu) + 8'(f4_reg.spd_te)
               + 8'(f4_reg.spd_on) + 8'(f4_reg.cnt_hu) + 8'(f4_reg.cnt_te)
               + 8'(f4_reg.cnt_on);
        f5_next      = f4_reg;
        f5_next.csum = CSUM_BASE + dsum;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg <= in_valid && in_range;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
            if (ready5) v5_reg <= v4_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ready1) begin
            spd1_reg <= in_speed[13:0];
            cnt1_reg <= in_count[9:0];
        end
        if (ready2) begin
            spd_th2_reg <= th_d;
            spd2_reg    <= s_rem2[9:0];
            cnt2_reg    <= cnt1_reg;
        end
        if (ready3) begin
            spd_th3_reg <= spd_th2_reg;
            spd_hu3_reg <= sh_d;
            cnt_hu3_reg <= ch_d;
            spd3_reg    <= s_rem3[6:0];
            cnt3_reg    <= c_rem3[6:0];
        end
        if (ready4) begin
            f4_reg.spd_th <= spd_th3_reg;
            f4_reg.spd_hu <= spd_hu3_reg;
            f4_reg.spd_te <= st_d;
            f4_reg.spd_on <= s_rem4[3:0];
            f4_reg.cnt_hu <= cnt_hu3_reg;
            f4_reg.cnt_te <= ct_d;
            f4_reg.cnt_on <= c_rem4[3:0];
            f4_reg.csum   <= 8'd0;
        end
        if (ready5) begin
            f5_reg <= f5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_frame = f5_reg;

endmodule

// ===== design/atf_serializer.sv =====
module atf_serializer
    import atf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  frame_t     in_frame,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    frame_t     frame_reg;
    logic [3:0] idx_reg;
    logic       busy_reg;
    logic       last;
    logic       done;

    assign last     = (idx_reg == POS_LINE_FEED);
    assign done     = busy_reg && out_ready && last;
    assign in_ready = !busy_reg || done;

    // Byte counter and frame holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= POS_HEAD_SPEED;
        end else if (in_valid && in_ready) begin
            busy_reg <= 1'b1;
            idx_reg  <= POS_HEAD_SPEED;
        end else if (busy_reg && out_ready) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            frame_reg <= in_frame;
        end
    end

    // Byte select
    always_comb begin
        unique case (idx_reg)
            POS_HEAD_SPEED: out_byte = HEAD_SPEED;
            POS_SPD_TH:     out_byte = to_ascii(frame_reg.spd_th);
            POS_SPD_HU:     out_byte = to_ascii(frame_reg.spd_hu);
            POS_SPD_TE:     out_byte = to_ascii(frame_reg.spd_te);
            POS_SPD_ON:     out_byte = to_ascii(frame_reg.spd_on);
            POS_HEAD_COUNT: out_byte = HEAD_COUNT;
            POS_CNT_HU:     out_byte = to_ascii(frame_reg.cnt_hu);
            POS_CNT_TE:     out_byte = to_ascii(frame_reg.cnt_te);
            POS_CNT_ON:     out_byte = to_ascii(frame_reg.cnt_on);
            POS_CSUM:       out_byte = frame_reg.csum;
            POS_LINE_FEED:  out_byte = LINE_FEED;
            default:        out_byte = LINE_FEED;
        endcase
    end

    assign out_valid = busy_reg;
    assign out_last  = last;

endmodule

// ===== design/ascii_telemetry_framer.sv =====
// The first frame byte reaches m_tx_byte after the digit stages and the serializer load.
// Frames are 11 bytes, their rate set by the single byte-wide result port; the 5-stage
// digit pipeline takes a new transaction every cycle unless held back by the serializer.
// Out-of-range inputs are accepted and produce no bytes.
// Reset (aresetn low, synchronous) empties the pipeline and the byte serializer.
module ascii_telemetry_framer
    import atf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_engine_speed,
    input  logic [15:0] s_pulse_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_byte
);

    logic   frm_valid;
    logic   frm_ready;
    frame_t frm;

    // Digit extraction and checksum pipeline
    atf_digits u_digits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_speed  (s_engine_speed),
        .in_count  (s_pulse_count),
        .out_valid (frm_valid),
        .out_ready (frm_ready),
        .out_frame (frm)
    );

    // Frame to byte stream
    atf_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frm_valid),
        .in_ready  (frm_ready),
        .in_frame  (frm),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_byte  (m_tx_byte),
        .out_last  (m_last_byte)
    );

endmodule
